@@ hw/rtl/lpr_pkg.sv @@
package lpr_pkg;

    // ring geometry
    localparam int BUF_BYTES    = 4096;
    localparam int HEADER_BYTES = 4;
    localparam int ALIGN_BYTES  = 4;
    localparam int MIN_RING     = 2 * HEADER_BYTES;

    localparam int ADDR_W = $clog2(BUF_BYTES);
    localparam int LEN_W  = ADDR_W + 1;
    localparam int CFG_W  = 13;
    localparam int PLEN_W = 16;
    localparam int CMP_W  = (LEN_W > PLEN_W + 1) ? LEN_W : PLEN_W + 1;

    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [CMP_W-1:0]  cmp_t;

    // request codes
    localparam logic [2:0] REQ_WRITE_BEGIN = 3'd0;
    localparam logic [2:0] REQ_WRITE_BYTE  = 3'd1;
    localparam logic [2:0] REQ_READ_BEGIN  = 3'd2;
    localparam logic [2:0] REQ_READ_BYTE   = 3'd3;
    localparam logic [2:0] REQ_PEEK        = 3'd4;

    // status codes
    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_INVALID  = 3'd1;
    localparam logic [2:0] STATUS_NO_SPACE = 3'd2;
    localparam logic [2:0] STATUS_EMPTY    = 3'd3;
    localparam logic [2:0] STATUS_CORRUPT  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_HDR,
        ST_RD_HI,
        ST_RD_LO,
        ST_RD_BYTE
    } lpr_state_t;

    typedef struct packed {
        logic [2:0]        status;
        logic [PLEN_W-1:0] length;
        logic [7:0]        byte_out;
        logic              last;
    } lpr_result_t;

    typedef struct packed {
        logic       wr_en;
        addr_t      wr_addr;
        logic [7:0] wr_data;
        logic       rd_en;
        addr_t      rd_addr;
    } lpr_mem_req_t;

    // ring length in use: low bits cleared, clamped between MIN_RING and the buffer
    function automatic len_t eff_len(input logic [CFG_W-1:0] v);
        logic [31:0] a;
        a = 32'({v[CFG_W-1:2], 2'b00});
        if (a < 32'(MIN_RING)) begin
            a = 32'(MIN_RING);
        end else if (a > 32'(BUF_BYTES)) begin
            a = 32'(BUF_BYTES);
        end
        return LEN_W'(a);
    endfunction

    // idx + k with one wrap, idx below n and k at most a header
    function automatic addr_t wrap_add(input addr_t idx, input logic [2:0] k, input len_t n);
        len_t s;
        s = len_t'(idx) + len_t'(k);
        if (s >= n) begin
            s = s - n;
        end
        return addr_t'(s);
    endfunction

    // round up to alignment, wrap to zero at the ring end
    function automatic addr_t commit_index(input len_t nx, input len_t n);
        len_t a;
        a = (nx + len_t'(ALIGN_BYTES - 1)) & ~len_t'(ALIGN_BYTES - 1);
        if (a >= n) begin
            a = '0;
        end
        return addr_t'(a);
    endfunction

    // bytes between read and write index
    function automatic len_t used_bytes(input addr_t w, input addr_t r, input len_t n);
        len_t u;
        if (r > w) begin
            u = n - (len_t'(r) - len_t'(w));
        end else begin
            u = len_t'(w) - len_t'(r);
        end
        return u;
    endfunction

endpackage

@@ hw/rtl/length_prefixed_packet_ring_core.sv @@
// Packet ring: a byte ring that holds length-prefixed packets.
// Input channel s_*: one beat per request (write_begin, write_byte,
// read_begin, read_byte, peek_length) with its operands on s_pkt_len,
// s_byte_in and s_read_capacity. Output channel m_*: exactly one result
// beat per request, in request order, with status, length, data byte
// and the last flag on the final data byte of a packet.
// One request is worked on at a time; the ring memory has one write
// port and one registered read port. read_begin and peek_length past
// the empty check do two header reads; write_begin writes four header
// bytes and pushes its result beat with the first of them.
// A result waits in the output register while m_ready is low; the next
// request is accepted meanwhile, and its own result stalls until the
// register drains.
// Reset (aresetn low, synchronous) empties the ring, closes any open
// packet and sets the ring length to the full buffer; memory contents
// are kept. cfg_wr_en loads a new ring length and also empties the ring.
module length_prefixed_packet_ring_core
    import lpr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_req_type,
    input  logic [PLEN_W-1:0]  s_pkt_len,
    input  logic [7:0]         s_byte_in,
    input  logic [PLEN_W-1:0]  s_read_capacity,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [PLEN_W-1:0]  m_length,
    output logic [7:0]         m_byte_out,
    output logic               m_last,
    input  logic               cfg_wr_en,
    input  logic [CFG_W-1:0]   cfg_wr_data
);

    lpr_mem_req_t mem_req;
    logic [7:0]   mem_rd_data;
    logic         out_free;
    logic         out_push;
    lpr_result_t  out_res;

    lpr_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_pkt_len       (s_pkt_len),
        .s_byte_in       (s_byte_in),
        .s_read_capacity (s_read_capacity),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .mem_req         (mem_req),
        .mem_rd_data     (mem_rd_data),
        .out_free        (out_free),
        .out_push        (out_push),
        .out_res         (out_res)
    );

    // ring storage
    lpr_ram #(
        .WIDTH (8),
        .DEPTH (BUF_BYTES)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (mem_req.wr_en),
        .wr_addr (mem_req.wr_addr),
        .wr_data (mem_req.wr_data),
        .rd_en   (mem_req.rd_en),
        .rd_addr (mem_req.rd_addr),
        .rd_data (mem_rd_data)
    );

    // result beat register
    lpr_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (out_push),
        .res        (out_res),
        .free       (out_free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_status   (m_status),
        .m_length   (m_length),
        .m_byte_out (m_byte_out),
        .m_last     (m_last)
    );

endmodule

@@ hw/rtl/lpr_ram.sv @@
module lpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hw/rtl/lpr_out.sv @@
module lpr_out
    import lpr_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push,
    input  lpr_result_t res,
    output logic        free,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [15:0] m_length,
    output logic [7:0]  m_byte_out,
    output logic        m_last
);

    logic        valid_reg;
    logic        valid_next;
    lpr_result_t data_reg;

    // slot can take a beat when empty or being drained
    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (push) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg <= res;
        end
    end

    assign m_valid    = valid_reg;
    assign m_status   = data_reg.status;
    assign m_length   = data_reg.length;
    assign m_byte_out = data_reg.byte_out;
    assign m_last     = data_reg.last;

endmodule

@@ hw/rtl/lpr_ctrl.sv @@
module lpr_ctrl
    import lpr_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_req_type,
    input  logic [PLEN_W-1:0]  s_pkt_len,
    input  logic [7:0]         s_byte_in,
    input  logic [PLEN_W-1:0]  s_read_capacity,
    input  logic               cfg_wr_en,
    input  logic [CFG_W-1:0]   cfg_wr_data,
    output lpr_mem_req_t       mem_req,
    input  logic [7:0]         mem_rd_data,
    input  logic               out_free,
    output logic               out_push,
    output lpr_result_t        out_res
);

    lpr_state_t        state_reg, state_next;
    len_t              n_reg, n_next;
    addr_t             widx_reg, widx_next;
    addr_t             ridx_reg, ridx_next;
    addr_t             wcur_reg, wcur_next;
    addr_t             rcur_reg, rcur_next;
    logic [PLEN_W-1:0] wleft_reg, wleft_next;
    logic [PLEN_W-1:0] rleft_reg, rleft_next;
    logic              wopen_reg, wopen_next;
    logic              ropen_reg, ropen_next;
    logic [2:0]        req_reg, req_next;
    logic [PLEN_W-1:0] plen_reg, plen_next;
    logic [7:0]        bin_reg, bin_next;
    logic [PLEN_W-1:0] cap_reg, cap_next;
    logic [1:0]        hdr_cnt_reg, hdr_cnt_next;
    logic [7:0]        hi_reg, hi_next;

    len_t              occ;
    len_t              freeb;
    logic [PLEN_W-1:0] pl;
    addr_t             rd_cur;
    logic [PLEN_W-1:0] wleft_dec;
    logic [PLEN_W-1:0] rleft_dec;

    assign s_ready = (state_reg == ST_IDLE);

    // occupancy and free space of the ring
    assign occ   = used_bytes(widx_reg, ridx_reg, n_reg);
    assign freeb = (occ + len_t'(HEADER_BYTES) <= n_reg) ?
                   (n_reg - occ - len_t'(HEADER_BYTES)) : '0;

    // stored length from the two header bytes
    assign pl        = {hi_reg, mem_rd_data};
    assign rd_cur    = wrap_add(ridx_reg, 3'(HEADER_BYTES), n_reg);
    assign wleft_dec = wleft_reg - PLEN_W'(1);
    assign rleft_dec = rleft_reg - PLEN_W'(1);

    // sequencer: next state, ring memory access and result beat
    always_comb begin
        state_next   = state_reg;
        n_next       = n_reg;
        widx_next    = widx_reg;
        ridx_next    = ridx_reg;
        wcur_next    = wcur_reg;
        rcur_next    = rcur_reg;
        wleft_next   = wleft_reg;
        rleft_next   = rleft_reg;
        wopen_next   = wopen_reg;
        ropen_next   = ropen_reg;
        req_next     = req_reg;
        plen_next    = plen_reg;
        bin_next     = bin_reg;
        cap_next     = cap_reg;
        hdr_cnt_next = hdr_cnt_reg;
        hi_next      = hi_reg;
        mem_req      = '0;
        out_push     = 1'b0;
        out_res      = '0;
        out_res.status = STATUS_INVALID;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_next   = s_req_type;
                    plen_next  = s_pkt_len;
                    bin_next   = s_byte_in;
                    cap_next   = s_read_capacity;
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                    unique case (req_reg)
                        REQ_WRITE_BEGIN: begin
                            if (plen_reg == '0 || wopen_reg) begin
                                out_push = 1'b1;
                            end else if (cmp_t'(freeb) <
                                         cmp_t'(plen_reg) + cmp_t'(HEADER_BYTES)) begin
                                out_push       = 1'b1;
                                out_res.status = STATUS_NO_SPACE;
                            end else begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = widx_reg;
                                mem_req.wr_data = plen_reg[15:8];
                                wcur_next    = wrap_add(widx_reg, 3'(HEADER_BYTES), n_reg);
                                wleft_next   = plen_reg;
                                wopen_next   = 1'b1;
                                hdr_cnt_next = 2'd1;
                                state_next   = ST_HDR;
                                out_push       = 1'b1;
                                out_res.status = STATUS_OK;
                                out_res.length = plen_reg;
                            end
                        end
                        REQ_WRITE_BYTE: begin
                            out_push = 1'b1;
                            if (wopen_reg) begin
                                mem_req.wr_en   = 1'b1;
                                mem_req.wr_addr = wcur_reg;
                                mem_req.wr_data = bin_reg;
                                wcur_next  = wrap_add(wcur_reg, 3'd1, n_reg);
                                wleft_next = wleft_dec;
                                out_res.status = STATUS_OK;
                                if (wleft_dec == '0) begin
                                    out_res.last = 1'b1;
                                    widx_next  = commit_index(len_t'(wcur_reg) + len_t'(1), n_reg);
                                    wopen_next = 1'b0;
                                end
                            end
                        end
                        REQ_READ_BEGIN, REQ_PEEK: begin
                            if (req_reg == REQ_READ_BEGIN && ropen_reg) begin
                                out_push = 1'b1;
                            end else if (ridx_reg == widx_reg) begin
                                out_push       = 1'b1;
                                out_res.status = STATUS_EMPTY;
                            end else begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = ridx_reg;
                                state_next      = ST_RD_HI;
                            end
                        end
                        REQ_READ_BYTE: begin
                            if (ropen_reg) begin
                                mem_req.rd_en   = 1'b1;
                                mem_req.rd_addr = rcur_reg;
                                state_next      = ST_RD_BYTE;
                            end else begin
                                out_push = 1'b1;
                            end
                        end
                        default: begin
                            out_push = 1'b1;
                        end
                    endcase
                end
            end

            // remaining header bytes: length low byte, then two zeros
            ST_HDR: begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = wrap_add(widx_reg, {1'b0, hdr_cnt_reg}, n_reg);
                mem_req.wr_data = (hdr_cnt_reg == 2'd1) ? plen_reg[7:0] : 8'd0;
                hdr_cnt_next    = hdr_cnt_reg + 2'd1;
                if (hdr_cnt_reg == 2'd3) begin
                    state_next = ST_IDLE;
                end
            end

            ST_RD_HI: begin
                hi_next         = mem_rd_data;
                mem_req.rd_en   = 1'b1;
                mem_req.rd_addr = wrap_add(ridx_reg, 3'd1, n_reg);
                state_next      = ST_RD_LO;
            end

            // header length known: peek, refuse, free an empty packet or open the packet
            ST_RD_LO: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                    out_push   = 1'b1;
                    if (req_reg == REQ_PEEK) begin
                        out_res.status = STATUS_OK;
                        out_res.length = pl;
                    end else if (pl > cap_reg) begin
                        out_res.status = STATUS_NO_SPACE;
                        out_res.length = pl;
                    end else if (cmp_t'(occ) < cmp_t'(pl) + cmp_t'(HEADER_BYTES)) begin
                        out_res.status = STATUS_CORRUPT;
                    end else begin
                        out_res.status = STATUS_OK;
                        out_res.length = pl;
                        if (pl == '0) begin
                            ridx_next = commit_index(len_t'(rd_cur), n_reg);
                        end else begin
                            rcur_next  = rd_cur;
                            rleft_next = pl;
                            ropen_next = 1'b1;
                        end
                    end
                end
            end

            ST_RD_BYTE: begin
                if (out_free) begin
                    state_next       = ST_IDLE;
                    out_push         = 1'b1;
                    out_res.status   = STATUS_OK;
                    out_res.byte_out = mem_rd_data;
                    rcur_next        = wrap_add(rcur_reg, 3'd1, n_reg);
                    rleft_next       = rleft_dec;
                    if (rleft_dec == '0) begin
                        out_res.last = 1'b1;
                        ridx_next  = commit_index(len_t'(rcur_reg) + len_t'(1), n_reg);
                        ropen_next = 1'b0;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // register write: new ring length, empty ring
        if (cfg_wr_en) begin
            n_next     = eff_len(cfg_wr_data);
            widx_next  = '0;
            ridx_next  = '0;
            wcur_next  = '0;
            rcur_next  = '0;
            wleft_next = '0;
            rleft_next = '0;
            wopen_next = 1'b0;
            ropen_next = 1'b0;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            n_reg     <= len_t'(BUF_BYTES);
            widx_reg  <= '0;
            ridx_reg  <= '0;
            wcur_reg  <= '0;
            rcur_reg  <= '0;
            wleft_reg <= '0;
            rleft_reg <= '0;
            wopen_reg <= 1'b0;
            ropen_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            n_reg     <= n_next;
            widx_reg  <= widx_next;
            ridx_reg  <= ridx_next;
            wcur_reg  <= wcur_next;
            rcur_reg  <= rcur_next;
            wleft_reg <= wleft_next;
            rleft_reg <= rleft_next;
            wopen_reg <= wopen_next;
            ropen_reg <= ropen_next;
        end
    end

    // item payload and scratch
    always_ff @(posedge aclk) begin
        req_reg     <= req_next;
        plen_reg    <= plen_next;
        bin_reg     <= bin_next;
        cap_reg     <= cap_next;
        hdr_cnt_reg <= hdr_cnt_next;
        hi_reg      <= hi_next;
    end

endmodule

@@ verif/tb.sv @@
module tb
    import lpr_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // request codes the block does not define
    localparam logic [2:0] REQ_RESERVED_LO = 3'd5;
    localparam logic [2:0] REQ_RESERVED_HI = 3'd7;

    localparam int PHASE_ITEMS = 125;

    // ring lengths per random phase, clamped and odd values among them
    localparam logic [CFG_W-1:0] PHASE_RING_LEN [12] = '{
        13'd16, 13'd0, 13'd8191, 13'd12, 13'd27, 13'd100,
        13'd4096, 13'd20, 13'd7, 13'd64, 13'd1024, 13'd40
    };

    typedef struct packed {
        logic [2:0]        req;
        logic [PLEN_W-1:0] plen;
        logic [7:0]        din;
        logic [PLEN_W-1:0] cap;
        logic              typed;
        lpr_result_t       res;
    } dir_row_t;

    // directed rows on the reset ring of 4096 bytes
    // req, pkt_len, byte_in, read_capacity, typed, {status, length, byte_out, last}
    localparam dir_row_t DIRECTED [25] = '{
        '{REQ_READ_BEGIN,  16'd0,    8'h00, 16'hFFFF, 1'b1, '{STATUS_EMPTY,    16'd0, 8'h00, 1'b0}},
        '{REQ_PEEK,        16'd0,    8'h00, 16'h0000, 1'b1, '{STATUS_EMPTY,    16'd0, 8'h00, 1'b0}},
        '{REQ_WRITE_BYTE,  16'd0,    8'hFF, 16'h0000, 1'b1, '{STATUS_INVALID,  16'd0, 8'h00, 1'b0}},
        '{REQ_READ_BYTE,   16'd0,    8'h00, 16'hFFFF, 1'b1, '{STATUS_INVALID,  16'd0, 8'h00, 1'b0}},
        '{REQ_WRITE_BEGIN, 16'd0,    8'h00, 16'h0000, 1'b1, '{STATUS_INVALID,  16'd0, 8'h00, 1'b0}},
        '{REQ_WRITE_BEGIN, 16'hFFFF, 8'h00, 16'h0000, 1'b1, '{STATUS_NO_SPACE, 16'd0, 8'h00, 1'b0}},
        '{REQ_WRITE_BEGIN, 16'd4089, 8'h00, 16'h0000, 1'b1, '{STATUS_NO_SPACE, 16'd0, 8'h00, 1'b0}},
        '{REQ_RESERVED_LO, 16'd0,    8'h00, 16'h0000, 1'b1, '{STATUS_INVALID,  16'd0, 8'h00, 1'b0}},
        '{REQ_RESERVED_HI, 16'hFFFF, 8'hFF, 16'hFFFF, 1'b1, '{STATUS_INVALID,  16'd0, 8'h00, 1'b0}},
        '{REQ_WRITE_BEGIN, 16'd3,    8'h00, 16'h0000, 1'b1, '{STATUS_OK,       16'd3, 8'h00, 1'b0}},
        '{REQ_WRITE_BEGIN, 16'd2,    8'h00, 16'h0000, 1'b1, '{STATUS_INVALID,  16'd0, 8'h00, 1'b0}},
        '{REQ_WRITE_BYTE,  16'd0,    8'h00, 16'h0000, 1'b0, '0},
        '{REQ_WRITE_BYTE,  16'd0,    8'hFF, 16'h0000, 1'b0, '0},
        '{REQ_WRITE_BYTE,  16'd0,    8'h5A, 16'h0000, 1'b0, '0},
        '{REQ_PEEK,        16'd0,    8'h00, 16'h0000, 1'b1, '{STATUS_OK,       16'd3, 8'h00, 1'b0}},
        '{REQ_READ_BEGIN,  16'd0,    8'h00, 16'd2,    1'b1, '{STATUS_NO_SPACE, 16'd3, 8'h00, 1'b0}},
        '{REQ_READ_BEGIN,  16'd0,    8'h00, 16'd3,    1'b1, '{STATUS_OK,       16'd3, 8'h00, 1'b0}},
        '{REQ_READ_BEGIN,  16'd0,    8'h00, 16'hFFFF, 1'b1, '{STATUS_INVALID,  16'd0, 8'h00, 1'b0}},
        '{REQ_PEEK,        16'd0,    8'h00, 16'h0000, 1'b1, '{STATUS_OK,       16'd3, 8'h00, 1'b0}},
        '{REQ_READ_BYTE,   16'd0,    8'h00, 16'h0000, 1'b1, '{STATUS_OK,       16'd0, 8'h00, 1'b0}},
        '{REQ_READ_BYTE,   16'd0,    8'h00, 16'h0000, 1'b1, '{STATUS_OK,       16'd0, 8'hFF, 1'b0}},
        '{REQ_READ_BYTE,   16'd0,    8'h00, 16'h0000, 1'b1, '{STATUS_OK,       16'd0, 8'h5A, 1'b1}},
        '{REQ_READ_BYTE,   16'd0,    8'h00, 16'h0000, 1'b1, '{STATUS_INVALID,  16'd0, 8'h00, 1'b0}},
        '{REQ_READ_BEGIN,  16'd0,    8'h00, 16'hFFFF, 1'b1, '{STATUS_EMPTY,    16'd0, 8'h00, 1'b0}},
        '{REQ_RESERVED_HI, 16'd0,    8'h00, 16'h0000, 1'b1, '{STATUS_INVALID,  16'd0, 8'h00, 1'b0}}
    };

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [2:0]        s_req_type = REQ_PEEK;
    logic [PLEN_W-1:0] s_pkt_len = '0;
    logic [7:0]        s_byte_in = '0;
    logic [PLEN_W-1:0] s_read_capacity = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic [2:0]        m_status;
    logic [PLEN_W-1:0] m_length;
    logic [7:0]        m_byte_out;
    logic              m_last;
    logic              cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]  cfg_wr_data = '0;

    // no idling on either side while set
    bit steady = 1'b0;
    int mismatches = 0;
    lpr_result_t pending_results [$];

    // shadow of the ring contents and pointers
    logic [7:0]       pkt_mem [BUF_BYTES] = '{default: 8'h00};
    logic [CFG_W-1:0] ring_len_reg = 13'd4096;
    int unsigned      wr_index = 0;
    int unsigned      rd_index = 0;
    int unsigned      wr_cursor = 0;
    int unsigned      rd_cursor = 0;
    int unsigned      wr_left = 0;
    int unsigned      rd_left = 0;
    bit               wr_open = 1'b0;
    bit               rd_open = 1'b0;

    always #1 aclk = ~aclk;

    length_prefixed_packet_ring_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_pkt_len       (s_pkt_len),
        .s_byte_in       (s_byte_in),
        .s_read_capacity (s_read_capacity),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_length        (m_length),
        .m_byte_out      (m_byte_out),
        .m_last          (m_last),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data)
    );

    // ring bytes in use: low bits dropped, clamped between MIN_RING and the buffer
    function automatic int unsigned ring_size();
        int unsigned v;
        v = int'(ring_len_reg) & ~3;
        if (v < MIN_RING) begin
            v = MIN_RING;
        end else if (v > BUF_BYTES) begin
            v = BUF_BYTES;
        end
        return v;
    endfunction

    function automatic int unsigned ring_wrap(input int unsigned x, input int unsigned n);
        return (x >= n) ? x % n : x;
    endfunction

    function automatic int unsigned align4(input int unsigned x);
        return (x + ALIGN_BYTES - 1) & ~(ALIGN_BYTES - 1);
    endfunction

    function automatic int unsigned occupied(input int unsigned n);
        return (rd_index > wr_index) ? n - (rd_index - wr_index) : wr_index - rd_index;
    endfunction

    // big-endian length in the header at the read index
    function automatic int unsigned stored_len(input int unsigned n);
        return 32'({pkt_mem[ADDR_W'(rd_index)], pkt_mem[ADDR_W'(ring_wrap(rd_index + 1, n))]});
    endfunction

    // expected result of one request, advancing the shadow state
    function automatic lpr_result_t predict_ring(input logic [2:0] req,
            input logic [PLEN_W-1:0] plen, input logic [7:0] din,
            input logic [PLEN_W-1:0] cap);
        lpr_result_t res;
        int unsigned n, occ, room, hl, nx, cur;
        n = ring_size();
        res = '0;
        res.status = STATUS_INVALID;
        wr_index = ring_wrap(wr_index, n);
        rd_index = ring_wrap(rd_index, n);
        case (req)
            REQ_WRITE_BEGIN: begin
                if (plen != 0 && !wr_open) begin
                    occ = occupied(n);
                    room = (occ + HEADER_BYTES <= n) ? n - occ - HEADER_BYTES : 0;
                    if (room < int'(plen) + HEADER_BYTES) begin
                        res.status = STATUS_NO_SPACE;
                    end else begin
                        pkt_mem[ADDR_W'(wr_index)] = plen[15:8];
                        pkt_mem[ADDR_W'(ring_wrap(wr_index + 1, n))] = plen[7:0];
                        pkt_mem[ADDR_W'(ring_wrap(wr_index + 2, n))] = 8'h00;
                        pkt_mem[ADDR_W'(ring_wrap(wr_index + 3, n))] = 8'h00;
                        wr_cursor = ring_wrap(wr_index + HEADER_BYTES, n);
                        wr_left = 32'(plen);
                        wr_open = 1'b1;
                        res.status = STATUS_OK;
                        res.length = plen;
                    end
                end
            end
            REQ_WRITE_BYTE: begin
                if (wr_open) begin
                    nx = wr_cursor + 1;
                    pkt_mem[ADDR_W'(wr_cursor)] = din;
                    wr_cursor = ring_wrap(nx, n);
                    wr_left = wr_left - 1;
                    res.status = STATUS_OK;
                    // last byte commits the packet at the next aligned slot
                    if (wr_left == 0) begin
                        res.last = 1'b1;
                        wr_index = ring_wrap(align4(nx), n);
                        wr_open = 1'b0;
                    end
                end
            end
            REQ_READ_BEGIN, REQ_PEEK: begin
                if (!(req == REQ_READ_BEGIN && rd_open)) begin
                    if (rd_index == wr_index) begin
                        res.status = STATUS_EMPTY;
                    end else begin
                        hl = stored_len(n);
                        if (req == REQ_PEEK) begin
                            res.status = STATUS_OK;
                            res.length = PLEN_W'(hl);
                        end else if (hl > 32'(cap)) begin
                            res.status = STATUS_NO_SPACE;
                            res.length = PLEN_W'(hl);
                        end else if (occupied(n) < hl + HEADER_BYTES) begin
                            res.status = STATUS_CORRUPT;
                        end else begin
                            cur = ring_wrap(rd_index + HEADER_BYTES, n);
                            res.status = STATUS_OK;
                            res.length = PLEN_W'(hl);
                            // an empty packet is freed right away
                            if (hl == 0) begin
                                rd_index = ring_wrap(align4(cur), n);
                            end else begin
                                rd_cursor = cur;
                                rd_left = hl;
                                rd_open = 1'b1;
                            end
                        end
                    end
                end
            end
            REQ_READ_BYTE: begin
                if (rd_open) begin
                    nx = rd_cursor + 1;
                    res.byte_out = pkt_mem[ADDR_W'(rd_cursor)];
                    rd_cursor = ring_wrap(nx, n);
                    rd_left = rd_left - 1;
                    res.status = STATUS_OK;
                    if (rd_left == 0) begin
                        res.last = 1'b1;
                        rd_index = ring_wrap(align4(nx), n);
                        rd_open = 1'b0;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // sender gap: mostly none, some short, a few long
    function automatic int idle_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (steady || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return int'($urandom_range(1, 3));
        end
        return int'($urandom_range(8, 40));
    endfunction

    // drive one beat, predict it on acceptance, return at the next falling edge
    task automatic send_request(input logic [2:0] req, input logic [PLEN_W-1:0] plen,
            input logic [7:0] din, input logic [PLEN_W-1:0] cap, input bit typed,
            input lpr_result_t typed_res, output lpr_result_t got);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid         <= 1'b1;
        s_req_type      <= req;
        s_pkt_len       <= plen;
        s_byte_in       <= din;
        s_read_capacity <= cap;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        got = predict_ring(req, plen, din, cap);
        pending_results.push_back(typed ? typed_res : got);
        @(negedge aclk);
    endtask

    // mostly well-formed packet traffic steered by the shadow state, some noise
    task automatic pick_request(output logic [2:0] req, output logic [PLEN_W-1:0] plen,
            output logic [7:0] din, output logic [PLEN_W-1:0] cap);
        int unsigned n, fit, hl;
        int r, k;
        n = ring_size();
        fit = (occupied(n) + 2 * HEADER_BYTES <= n) ? n - occupied(n) - 2 * HEADER_BYTES : 0;
        hl = (rd_index != wr_index) ? stored_len(n) : 0;
        plen = PLEN_W'($urandom_range(0, 65535));
        din = 8'($urandom_range(0, 255));
        cap = PLEN_W'($urandom_range(0, 65535));
        req = REQ_PEEK;
        r = int'($urandom_range(0, 99));
        if (r < 4) begin
            req = 3'($urandom_range(0, 7));
        end else if (wr_open && r < 70) begin
            req = REQ_WRITE_BYTE;
        end else if (rd_open && r < 90) begin
            req = REQ_READ_BYTE;
        end else begin
            k = int'($urandom_range(0, 99));
            if (k < 45) begin
                req = REQ_WRITE_BEGIN;
                k = int'($urandom_range(0, 99));
                if (k < 55) begin
                    plen = PLEN_W'($urandom_range(1, 8));
                end else if (k < 80) begin
                    plen = PLEN_W'($urandom_range(9, 40));
                end else if (k < 90) begin
                    // exactly fills the free space
                    plen = PLEN_W'((fit >= 1 && fit <= 96) ? fit : $urandom_range(1, 8));
                end else if (k < 95) begin
                    // one byte too many
                    plen = PLEN_W'(fit + 1);
                end else begin
                    plen = PLEN_W'($urandom_range(41, 300));
                end
            end else if (k < 80) begin
                req = REQ_READ_BEGIN;
                k = int'($urandom_range(0, 99));
                if (k < 20) begin
                    cap = PLEN_W'(hl);
                end else if (k < 35 && hl > 0) begin
                    cap = PLEN_W'($urandom_range(0, hl - 1));
                end else if (k < 70) begin
                    cap = 16'hFFFF;
                end
            end
        end
    endtask

    // let every result drain and the header writes finish
    task automatic wait_idle();
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (8) @(negedge aclk);
    endtask

    // new ring length, which also empties the ring
    task automatic load_ring_len(input logic [CFG_W-1:0] v);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en    <= 1'b0;
        ring_len_reg = v;
        wr_index = 0;
        rd_index = 0;
        wr_cursor = 0;
        rd_cursor = 0;
        wr_left = 0;
        rd_left = 0;
        wr_open = 1'b0;
        rd_open = 1'b0;
    endtask

    // reset
    initial begin
        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
    end

    // result side stalls
    initial begin : rx_stall
        int run;
        int r;
        @(negedge aclk);
        forever begin
            r = int'($urandom_range(0, 99));
            if (steady || r < 55) begin
                m_ready <= 1'b1;
                run = int'($urandom_range(1, 24));
            end else if (r < 90) begin
                m_ready <= 1'b0;
                run = int'($urandom_range(1, 3));
            end else begin
                m_ready <= 1'b0;
                run = int'($urandom_range(10, 60));
            end
            repeat (run) @(negedge aclk);
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge aclk) begin : result_check
        lpr_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result beat with nothing expected: status %0d", m_status);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (m_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    mismatches++;
                end
                if (m_length !== want.length) begin
                    $error("length: expected %0d, got %0d", want.length, m_length);
                    mismatches++;
                end
                if (m_byte_out !== want.byte_out) begin
                    $error("byte_out: expected 0x%02h, got 0x%02h", want.byte_out, m_byte_out);
                    mismatches++;
                end
                if (m_last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_last);
                    mismatches++;
                end
            end
        end
    end

    // stimulus
    initial begin : stimulus
        logic [2:0]        req;
        logic [PLEN_W-1:0] plen;
        logic [7:0]        din;
        logic [PLEN_W-1:0] cap;
        lpr_result_t       got;
        int                done;
        wait (aresetn);
        @(negedge aclk);

        // directed beats on the reset ring length
        foreach (DIRECTED[i]) begin
            send_request(DIRECTED[i].req, DIRECTED[i].plen, DIRECTED[i].din,
                DIRECTED[i].cap, DIRECTED[i].typed, DIRECTED[i].res, got);
        end

        // random traffic, one phase per ring length
        for (int p = 0; p < $size(PHASE_RING_LEN); p++) begin
            s_valid <= 1'b0;
            wait_idle();
            load_ring_len(PHASE_RING_LEN[p]);
            steady = (p % 4 == 3);
            done = 0;
            while (done < PHASE_ITEMS) begin
                pick_request(req, plen, din, cap);
                send_request(req, plen, din, cap, 1'b0, '0, got);
                done++;
            end
        end
        s_valid <= 1'b0;
        steady = 1'b0;
        wait_idle();

        if (mismatches == 0) begin
            $display("length_prefixed_packet_ring_core regression: pass");
        end else begin
            $display("length_prefixed_packet_ring_core regression: fail");
        end
        $finish;
    end

    // hang guard
    initial begin
        #2_000_000;
        $display("length_prefixed_packet_ring_core regression: fail");
        $finish;
    end

endmodule
